// File: rtl/pwl_lvl_pkg.sv
`timescale 1ns / 1ps
package pwl_lvl_pkg;

  localparam int MAX_POINTS_DEF = 16;

  localparam int CUR_W   = 19;
  localparam int FRAC_W  = 17;
  localparam int PIDX_W  = 4;
  localparam int LEVEL_W = 21;
  localparam int CFG_W   = 18;
  localparam int CFG_IDX_W = 3;

  localparam int DY_W   = FRAC_W + 1;
  localparam int DXC_W  = CUR_W + 1;
  localparam int NUM_W  = DY_W + DXC_W;
  localparam int DVD_W  = NUM_W + 1;
  localparam int F_W    = DVD_W + 2;
  localparam int RD_W   = CFG_W + 1;
  localparam int MPLR_W = RD_W;
  localparam int ACC_W  = 64;
  localparam int BASE_W = 46;
  localparam int LVL_W  = 52;
  localparam int CNT_W  = 6;

  localparam int LEVEL_LIMIT = 1000000;

  localparam logic [CFG_IDX_W-1:0] CFG_POINT_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MIN   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_MAX   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET      = 3'd4;

  typedef struct packed {
    logic [0:0]         opcode;
    logic [PIDX_W-1:0]  point_index;
    logic [CUR_W-1:0]   point_current;
    logic [FRAC_W-1:0]  point_fraction;
    logic [CUR_W-1:0]   sample_current;
    logic [0:0]         sample_valid;
  } in_item_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] level_mm;
    logic [0:0]                result_ok;
    logic [0:0]                level_saturated;
  } out_item_t;

  typedef struct packed {
    logic [4:0]         point_count;
    logic signed [17:0] range_min_mm;
    logic signed [17:0] range_max_mm;
    logic [15:0]        gain_q12;
    logic signed [16:0] offset_mm;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    point_count:  5'd2,
    range_min_mm: 18'sd0,
    range_max_mm: 18'sd10000,
    gain_q12:     16'd4096,
    offset_mm:    17'sd0
  };

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_CONV,
    OP_HOLD
  } op_kind_t;

  typedef struct packed {
    op_kind_t           kind;
    logic [PIDX_W-1:0]  idx;
    logic [CUR_W-1:0]   cur;
    logic [FRAC_W-1:0]  frac;
  } op_t;

  typedef struct packed {
    logic [CUR_W-1:0]  x;
    logic [FRAC_W-1:0] y;
  } entry_t;

  localparam int ENTRY_W = CUR_W + FRAC_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD0,
    ST_SRCH,
    ST_PREP,
    ST_NORM,
    ST_DIV,
    ST_FRAC,
    ST_MSET1,
    ST_MUL1,
    ST_BASE,
    ST_MSET2,
    ST_MUL2,
    ST_LVL,
    ST_CLIP
  } back_state_t;

  function automatic entry_t rst_entry(input logic is_zero, input logic is_one);
    entry_t e;
    e = '0;
    if (is_zero) begin
      e.x = CUR_W'(40000);
      e.y = '0;
    end else if (is_one) begin
      e.x = CUR_W'(200000);
      e.y = FRAC_W'(65536);
    end
    return e;
  endfunction

endpackage

// File: rtl/pwl_lvl_chan.sv
`timescale 1ns / 1ps
interface pwl_lvl_chan #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/pwl_lvl_ram.sv
`timescale 1ns / 1ps
module pwl_lvl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end
endmodule

// File: rtl/pwl_lvl_front.sv
`timescale 1ns / 1ps
module pwl_lvl_front #(
  parameter int MAX_POINTS = pwl_lvl_pkg::MAX_POINTS_DEF
) (
  pwl_lvl_chan.sink         in_ch,
  input  logic              q_full,
  output logic              q_push,
  output pwl_lvl_pkg::op_t  q_op
);
  import pwl_lvl_pkg::*;

  logic drop;

  always_comb begin
    q_op.idx = in_ch.data.point_index;
    if (in_ch.data.opcode == 1'b0) begin
      q_op.kind = OP_WRITE;
      q_op.cur  = in_ch.data.point_current;
      q_op.frac = in_ch.data.point_fraction;
    end else begin
      q_op.kind = (in_ch.data.sample_valid == 1'b1) ? OP_CONV : OP_HOLD;
      q_op.cur  = in_ch.data.sample_current;
      q_op.frac = in_ch.data.point_fraction;
    end
  end

  // drop point writes beyond the table
  assign drop = (in_ch.data.opcode == 1'b0) && (int'(in_ch.data.point_index) >= MAX_POINTS);
  assign in_ch.ready = !q_full;
  assign q_push = in_ch.valid && !q_full && !drop;
endmodule

// File: rtl/pwl_lvl_queue.sv
`timescale 1ns / 1ps
module pwl_lvl_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  pwl_lvl_pkg::op_t  push_op,
  output logic              full,
  output logic              valid,
  output pwl_lvl_pkg::op_t  head,
  input  logic              pop
);
  import pwl_lvl_pkg::*;

  op_t        slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) begin
      slot_r[wp_r] <= push_op;
    end
  end
endmodule

// File: rtl/pwl_lvl_back.sv
`timescale 1ns / 1ps
module pwl_lvl_back #(
  parameter int MAX_POINTS = pwl_lvl_pkg::MAX_POINTS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  pwl_lvl_pkg::op_t  q_op,
  output logic              q_pop,
  input  pwl_lvl_pkg::cfg_t cfg,
  pwl_lvl_chan.source       out_ch
);
  import pwl_lvl_pkg::*;

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam logic signed [LVL_W-1:0] LIM = LVL_W'(LEVEL_LIMIT);

  back_state_t state_r, state_nxt;

  logic [MAX_POINTS-1:0] vld_r, vld_nxt;
  logic [IDX_W-1:0]      idx_r, idx_nxt, rd_addr, rd_addr_r, last;
  logic                  rd_vld_r;
  logic                  ram_we;
  logic [ENTRY_W-1:0]    ram_q;
  entry_t                entry, prev_r, prev_nxt, cur_r, cur_nxt;
  logic                  advance;

  logic [CUR_W-1:0]         c_r, c_nxt, den_r, den_nxt, den_c, rem_r, rem_nxt, div_rem;
  logic signed [NUM_W-1:0]  num_r, num_nxt, num_c;
  logic [NUM_W-1:0]         num_mag;
  logic [DVD_W-1:0]         dvd_r, dvd_nxt;
  logic [CUR_W:0]           div_sh;
  logic                     div_ge;
  logic [CNT_W-1:0]         cnt_r, cnt_nxt;
  logic                     neg_r, neg_nxt;
  logic signed [DY_W-1:0]   dy;
  logic signed [DXC_W-1:0]  dxc;
  logic [F_W-1:0]           f_c, f_abs;
  logic signed [F_W-1:0]    f_r, f_nxt;
  logic signed [RD_W-1:0]   rd_c;
  logic [RD_W-1:0]          rd_abs;
  logic [ACC_W-1:0]         acc_r, acc_nxt, mcand_r, mcand_nxt, acc_add, rnd16, rnd12;
  logic [MPLR_W-1:0]        mplr_r, mplr_nxt;
  logic signed [BASE_W-1:0] base_r, base_nxt, base_c, r16s;
  logic [BASE_W-1:0]        base_abs;
  logic signed [LVL_W-1:0]  lvl_r, lvl_nxt, lvl_c, r12s;
  logic signed [LEVEL_W-1:0] held_r, held_nxt, clip_val;
  logic                     clip_sat;
  out_item_t                out_r, out_nxt;
  logic                     out_vld_r, out_vld_nxt;
  logic                     slot_free;

  pwl_lvl_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_POINTS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (IDX_W'(q_op.idx)),
    .wdata ({q_op.cur, q_op.frac}),
    .raddr (rd_addr),
    .rdata (ram_q)
  );

  always_comb begin
    if (cfg.point_count < 5'd2) begin
      last = IDX_W'(1);
    end else if (int'(cfg.point_count) > MAX_POINTS) begin
      last = IDX_W'(MAX_POINTS - 1);
    end else begin
      last = IDX_W'(cfg.point_count - 5'd1);
    end
  end

  assign entry = rd_vld_r ? entry_t'(ram_q)
                          : rst_entry(rd_addr_r == '0, rd_addr_r == IDX_W'(1));
  assign advance = (idx_r < last) && (c_r > entry.x);
  assign slot_free = !out_vld_r || out_ch.ready;

  assign dy    = $signed({1'b0, cur_r.y}) - $signed({1'b0, prev_r.y});
  assign dxc   = (cur_r.x > prev_r.x) ? ($signed({1'b0, c_r}) - $signed({1'b0, prev_r.x}))
                                      : ($signed({1'b0, prev_r.x}) - $signed({1'b0, c_r}));
  assign den_c = (cur_r.x > prev_r.x) ? (cur_r.x - prev_r.x) : (prev_r.x - cur_r.x);
  assign num_c = NUM_W'(dy) * NUM_W'(dxc);
  assign num_mag = num_r[NUM_W-1] ? NUM_W'(-num_r) : NUM_W'(num_r);

  assign div_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign div_ge  = div_sh >= {1'b0, den_r};
  assign div_rem = div_ge ? CUR_W'(div_sh - {1'b0, den_r}) : CUR_W'(div_sh);

  assign f_c   = neg_r ? (F_W'(prev_r.y) - F_W'(dvd_r)) : (F_W'(prev_r.y) + F_W'(dvd_r));
  assign f_abs = f_r[F_W-1] ? F_W'(-f_r) : F_W'(f_r);
  assign rd_c  = RD_W'(cfg.range_max_mm) - RD_W'(cfg.range_min_mm);
  assign rd_abs = rd_c[RD_W-1] ? RD_W'(-rd_c) : RD_W'(rd_c);

  assign acc_add = acc_r + (mplr_r[0] ? mcand_r : '0);
  assign rnd16   = (acc_r + ACC_W'(32768)) >> 16;
  assign rnd12   = (acc_r + ACC_W'(2048)) >> 12;
  assign r16s    = BASE_W'(rnd16);
  assign base_c  = BASE_W'(cfg.range_min_mm) + (neg_r ? -r16s : r16s);
  assign base_abs = base_r[BASE_W-1] ? BASE_W'(-base_r) : BASE_W'(base_r);
  assign r12s    = LVL_W'(rnd12);
  assign lvl_c   = (neg_r ? -r12s : r12s) - LVL_W'(cfg.offset_mm);

  always_comb begin
    clip_sat = 1'b0;
    clip_val = LEVEL_W'(lvl_r);
    if (lvl_r > LIM) begin
      clip_sat = 1'b1;
      clip_val = LEVEL_W'(LIM);
    end else if (lvl_r < -LIM) begin
      clip_sat = 1'b1;
      clip_val = LEVEL_W'(-LIM);
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_valid && (q_op.kind == OP_CONV)) begin
          state_nxt = ST_RD0;
        end
      end
      ST_RD0: state_nxt = ST_SRCH;
      ST_SRCH: begin
        if (!advance) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP:  state_nxt = (cur_r.x == prev_r.x) ? ST_FRAC : ST_NORM;
      ST_NORM:  state_nxt = ST_DIV;
      ST_DIV: begin
        if (cnt_r == CNT_W'(1)) begin
          state_nxt = ST_FRAC;
        end
      end
      ST_FRAC:  state_nxt = ST_MSET1;
      ST_MSET1: state_nxt = ST_MUL1;
      ST_MUL1: begin
        if (mplr_r == '0) begin
          state_nxt = ST_BASE;
        end
      end
      ST_BASE:  state_nxt = ST_MSET2;
      ST_MSET2: state_nxt = ST_MUL2;
      ST_MUL2: begin
        if (mplr_r == '0) begin
          state_nxt = ST_LVL;
        end
      end
      ST_LVL:   state_nxt = ST_CLIP;
      ST_CLIP: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    q_pop       = 1'b0;
    ram_we      = 1'b0;
    rd_addr     = '0;
    vld_nxt     = vld_r;
    idx_nxt     = idx_r;
    prev_nxt    = prev_r;
    cur_nxt     = cur_r;
    c_nxt       = c_r;
    num_nxt     = num_r;
    den_nxt     = den_r;
    dvd_nxt     = dvd_r;
    rem_nxt     = rem_r;
    cnt_nxt     = cnt_r;
    neg_nxt     = neg_r;
    f_nxt       = f_r;
    acc_nxt     = acc_r;
    mcand_nxt   = mcand_r;
    mplr_nxt    = mplr_r;
    base_nxt    = base_r;
    lvl_nxt     = lvl_r;
    held_nxt    = held_r;
    out_nxt     = out_r;
    out_vld_nxt = out_vld_r && !out_ch.ready;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_op.kind)
            OP_WRITE: begin
              q_pop  = 1'b1;
              ram_we = 1'b1;
              vld_nxt[IDX_W'(q_op.idx)] = 1'b1;
            end
            OP_CONV: begin
              q_pop   = 1'b1;
              c_nxt   = q_op.cur;
              idx_nxt = IDX_W'(1);
            end
            OP_HOLD: begin
              if (slot_free) begin
                q_pop                   = 1'b1;
                out_nxt.level_mm        = held_r;
                out_nxt.result_ok       = 1'b0;
                out_nxt.level_saturated = 1'b0;
                out_vld_nxt             = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_RD0: begin
        prev_nxt = entry;
        rd_addr  = IDX_W'(1);
      end
      ST_SRCH: begin
        if (advance) begin
          prev_nxt = entry;
          idx_nxt  = idx_r + IDX_W'(1);
          rd_addr  = idx_r + IDX_W'(1);
        end else begin
          cur_nxt = entry;
        end
      end
      ST_PREP: begin
        num_nxt = num_c;
        den_nxt = den_c;
        dvd_nxt = '0;
        neg_nxt = 1'b0;
      end
      ST_NORM: begin
        neg_nxt = num_r[NUM_W-1];
        dvd_nxt = DVD_W'(num_mag) + DVD_W'(den_r >> 1);
        rem_nxt = '0;
        cnt_nxt = CNT_W'(DVD_W);
      end
      ST_DIV: begin
        rem_nxt = div_rem;
        dvd_nxt = {dvd_r[DVD_W-2:0], div_ge};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      ST_FRAC: f_nxt = $signed(f_c);
      ST_MSET1: begin
        mcand_nxt = ACC_W'(f_abs);
        mplr_nxt  = MPLR_W'(rd_abs);
        neg_nxt   = f_r[F_W-1] ^ rd_c[RD_W-1];
        acc_nxt   = '0;
      end
      ST_MUL1, ST_MUL2: begin
        if (mplr_r != '0) begin
          acc_nxt   = acc_add;
          mcand_nxt = mcand_r << 1;
          mplr_nxt  = mplr_r >> 1;
        end
      end
      ST_BASE: base_nxt = base_c;
      ST_MSET2: begin
        mcand_nxt = ACC_W'(base_abs);
        mplr_nxt  = MPLR_W'(cfg.gain_q12);
        neg_nxt   = base_r[BASE_W-1];
        acc_nxt   = '0;
      end
      ST_LVL: lvl_nxt = lvl_c;
      ST_CLIP: begin
        if (slot_free) begin
          out_nxt.level_mm        = clip_val;
          out_nxt.result_ok       = 1'b1;
          out_nxt.level_saturated = clip_sat;
          out_vld_nxt             = 1'b1;
          held_nxt                = clip_val;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      vld_r     <= '0;
      held_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      vld_r     <= vld_nxt;
      held_r    <= held_nxt;
      out_vld_r <= out_vld_nxt;
    end
    rd_addr_r <= rd_addr;
    rd_vld_r  <= vld_r[rd_addr];
    idx_r     <= idx_nxt;
    prev_r    <= prev_nxt;
    cur_r     <= cur_nxt;
    c_r       <= c_nxt;
    num_r     <= num_nxt;
    den_r     <= den_nxt;
    dvd_r     <= dvd_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    neg_r     <= neg_nxt;
    f_r       <= f_nxt;
    acc_r     <= acc_nxt;
    mcand_r   <= mcand_nxt;
    mplr_r    <= mplr_nxt;
    base_r    <= base_nxt;
    lvl_r     <= lvl_nxt;
    out_r     <= out_nxt;
  end

  assign out_ch.valid = out_vld_r;
  assign out_ch.data  = out_r;
endmodule

// File: rtl/piecewise_linear_sensor_level_top.sv
`timescale 1ns / 1ps
// Level linearizer for a 4-20 mA loop: point writes load the calibration table, converts map a
// current through the table, range, gain and offset to a level in mm. A two-deep queue sits
// between the input and the compute engine, and one output register holds a finished result.
// A point write is taken straight from the queue by the engine; an invalid sample re-emits the
// held level once the output register is free. A valid convert runs a segment search (k segments
// visited, at most MAX_POINTS - 1, one table read per cycle on the single read port), a serial
// divide (skipped on a flat segment) and two shift-add multiplies (shorter for small range span
// and gain), and may then wait for the output register to free up.
module piecewise_linear_sensor_level_top #(
  parameter int MAX_POINTS = pwl_lvl_pkg::MAX_POINTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  pwl_lvl_chan.sink                             in_ch,
  pwl_lvl_chan.source                           out_ch,
  input  logic                                  cfg_we,
  input  logic [pwl_lvl_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [pwl_lvl_pkg::CFG_W-1:0]         cfg_data
);
  import pwl_lvl_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic q_push, q_full, q_valid, q_pop;
  op_t  q_in, q_head;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_POINT_COUNT: cfg_nxt.point_count  = cfg_data[4:0];
        CFG_RANGE_MIN:   cfg_nxt.range_min_mm = cfg_data[17:0];
        CFG_RANGE_MAX:   cfg_nxt.range_max_mm = cfg_data[17:0];
        CFG_GAIN:        cfg_nxt.gain_q12     = cfg_data[15:0];
        CFG_OFFSET:      cfg_nxt.offset_mm    = cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  pwl_lvl_front #(.MAX_POINTS(MAX_POINTS)) u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_op   (q_in)
  );

  pwl_lvl_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_op (q_in),
    .full    (q_full),
    .valid   (q_valid),
    .head    (q_head),
    .pop     (q_pop)
  );

  pwl_lvl_back #(.MAX_POINTS(MAX_POINTS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_op    (q_head),
    .q_pop   (q_pop),
    .cfg     (cfg_r),
    .out_ch  (out_ch)
  );

  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> ($signed(out_ch.data.level_mm) <= 21'sd1000000) &&
                     ($signed(out_ch.data.level_mm) >= -21'sd1000000))
    else $error("level outside output range");

  a_sat_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.level_saturated |-> out_ch.data.result_ok)
    else $error("saturation flagged on held level");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.data.level_saturated |->
      ($signed(out_ch.data.level_mm) == 21'sd1000000) ||
      ($signed(out_ch.data.level_mm) == -21'sd1000000))
    else $error("saturated level not at limit");
endmodule
